@@ design/receive_window_ack_tracker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// receive_window_ack_tracker_unit_macros.svh
// Assertion macros shared by the receive window tracker.
// ----------------------------------------------------------------------------
`ifndef RECEIVE_WINDOW_ACK_TRACKER_UNIT_MACROS_SVH
`define RECEIVE_WINDOW_ACK_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RWAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define RWAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rwat_pkg.sv @@
// ----------------------------------------------------------------------------
// rwat_pkg
// Widths and disposition codes of the receive window tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwat_pkg;

    localparam int SEQ_W      = 32;
    localparam int DISP_W     = 3;
    localparam int ACK_MASK_W = 32;

    typedef enum logic [DISP_W-1:0] {
        DISP_NEWEST    = 3'd0,
        DISP_REORDERED = 3'd1,
        DISP_DUPLICATE = 3'd2,
        DISP_STALE     = 3'd3,
        DISP_INVALID   = 3'd4
    } disp_t;

endpackage

@@ design/receive_window_ack_tracker_unit.sv @@
// An accepted beat waits in the input register until the result register is free,
// then is classified and loaded there. Throughput: one sequence number per cycle
// while the result channel does not stall, through the combinational classify
// and window shift. The input side stalls only while a held beat waits behind a
// stalled result. Reset (rst_n low, asynchronous) empties both registers, clears
// the newest sequence to zero (nothing received) and clears the arrival bitmap.
// ----------------------------------------------------------------------------
// receive_window_ack_tracker_unit
// Anti-replay receive window: classifies each sequence number and reports
// the acknowledgement sequence and bitmap after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "receive_window_ack_tracker_unit_macros.svh"

module receive_window_ack_tracker_unit #(
    parameter int WINDOW_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rwat_pkg::SEQ_W-1:0]      seq_number,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rwat_pkg::DISP_W-1:0]     disposition,
    output logic [rwat_pkg::SEQ_W-1:0]      ack_seq,
    output logic [rwat_pkg::ACK_MASK_W-1:0] ack_mask
);
    import rwat_pkg::*;

    logic                   held_valid;
    logic [SEQ_W-1:0]       held_seq;
    logic                   free;
    logic                   fire;
    disp_t                  disp;
    logic [SEQ_W-1:0]       newest_reg;
    logic [SEQ_W-1:0]       newest_next;
    logic [WINDOW_BITS-1:0] mask_reg;
    logic [WINDOW_BITS-1:0] mask_next;
    logic [ACK_MASK_W-1:0]  ack_mask_low;

    // Hold the incoming beat
    rwat_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .seq_number (seq_number),
        .advance    (free),
        .held_valid (held_valid),
        .held_seq   (held_seq)
    );

    // Classify against the current window
    rwat_classify #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_classify (
        .seq         (held_seq),
        .newest      (newest_reg),
        .mask        (mask_reg),
        .disp        (disp),
        .newest_next (newest_next),
        .mask_next   (mask_next)
    );

    assign fire = held_valid && free;

    // Advance the window state with each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            mask_reg   <= '0;
        end
        else if (fire)
        begin
            newest_reg <= newest_next;
            mask_reg   <= mask_next;
        end
    end

    // Report the low part of the bitmap, zero-extended for narrow windows
    if (WINDOW_BITS >= ACK_MASK_W)
    begin : g_mask_wide
        assign ack_mask_low = mask_next[ACK_MASK_W-1:0];
    end
    else
    begin : g_mask_narrow
        assign ack_mask_low = {{(ACK_MASK_W - WINDOW_BITS){1'b0}}, mask_next};
    end

    // Register the result beat
    rwat_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .disp_in     (disp),
        .ack_seq_in  (newest_next),
        .ack_mask_in (ack_mask_low),
        .free        (free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .disposition (disposition),
        .ack_seq     (ack_seq),
        .ack_mask    (ack_mask)
    );

    `RWAT_ASSERT_NEXT(a_reject_keeps_state, clk, rst_n,
        fire && (disp == DISP_INVALID || disp == DISP_STALE),
        $stable(newest_reg) && $stable(mask_reg), "rejected beat changed window state")

    `RWAT_ASSERT_NEXT(a_newest_sticks, clk, rst_n, newest_reg != '0, newest_reg != '0,
        "newest sequence returned to zero")

    `RWAT_ASSERT_NEXT(a_reorder_adds_one, clk, rst_n, fire && disp == DISP_REORDERED,
        $countones(mask_reg) == $countones($past(mask_reg)) + 1,
        "reordered beat did not set exactly one bitmap bit")

    `RWAT_ASSERT_NOW(a_newest_nonzero, clk, rst_n,
        out_valid && disposition == DISP_W'(DISP_NEWEST), ack_seq != '0,
        "newest result with zero acknowledgement sequence")

endmodule

@@ design/rwat_in_stage.sv @@
// ----------------------------------------------------------------------------
// rwat_in_stage
// Input register: captures one sequence number beat and holds it until the
// result stage can take it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwat_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rwat_pkg::SEQ_W-1:0]  seq_number,
    input  logic                        advance,
    output logic                        held_valid,
    output logic [rwat_pkg::SEQ_W-1:0]  held_seq
);
    import rwat_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [SEQ_W-1:0] seq_reg;
    logic             take;

    // Stall only while a held beat cannot move on
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // Refill or drain the holding slot
    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload of an accepted beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_reg <= seq_number;
        end
    end

    assign held_valid = valid_reg;
    assign held_seq   = seq_reg;

endmodule

@@ design/rwat_classify.sv @@
// ----------------------------------------------------------------------------
// rwat_classify
// Classifies one sequence number against the window and works out the next
// newest sequence and arrival bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwat_classify #(
    parameter int WINDOW_BITS = 32
) (
    input  logic [rwat_pkg::SEQ_W-1:0]  seq,
    input  logic [rwat_pkg::SEQ_W-1:0]  newest,
    input  logic [WINDOW_BITS-1:0]      mask,
    output rwat_pkg::disp_t             disp,
    output logic [rwat_pkg::SEQ_W-1:0]  newest_next,
    output logic [WINDOW_BITS-1:0]      mask_next
);
    import rwat_pkg::*;

    localparam int SHW = $clog2(WINDOW_BITS + 1);
    localparam int IW  = $clog2(WINDOW_BITS);

    logic [SEQ_W-1:0]       dist_new;
    logic [SEQ_W-1:0]       dist_old;
    logic [SHW-1:0]         sh_new;
    logic [WINDOW_BITS-1:0] lsb_one;
    logic [WINDOW_BITS-1:0] top_bit;
    logic [WINDOW_BITS-1:0] hole_bit;

    // Distances in both directions, modulo 2^32
    assign dist_new = seq - newest;
    assign dist_old = newest - seq;
    assign sh_new   = SHW'(dist_new);
    assign lsb_one  = WINDOW_BITS'(1);
    assign top_bit  = lsb_one << IW'(dist_new - SEQ_W'(1));
    assign hole_bit = lsb_one << IW'(dist_old - SEQ_W'(1));

    // Decide the disposition and the state update
    always_comb
    begin
        disp        = DISP_STALE;
        newest_next = newest;
        mask_next   = mask;
        if (seq == '0)
        begin
            disp = DISP_INVALID;
        end
        else if (newest == '0)
        begin
            // First packet: take it as newest, leave the bitmap alone
            disp        = DISP_NEWEST;
            newest_next = seq;
        end
        else if (seq == newest)
        begin
            disp = DISP_DUPLICATE;
        end
        else if (!dist_new[SEQ_W-1])
        begin
            // Newer: slide the bitmap up, or clear it past the window
            disp        = DISP_NEWEST;
            newest_next = seq;
            if (dist_new > SEQ_W'(WINDOW_BITS))
            begin
                mask_next = '0;
            end
            else
            begin
                mask_next = (mask << sh_new) | top_bit;
            end
        end
        else if (dist_old <= SEQ_W'(WINDOW_BITS))
        begin
            // Older but inside the window: fill the hole or flag a repeat
            if ((mask & hole_bit) != '0)
            begin
                disp = DISP_DUPLICATE;
            end
            else
            begin
                disp      = DISP_REORDERED;
                mask_next = mask | hole_bit;
            end
        end
    end

endmodule

@@ design/rwat_out_stage.sv @@
// ----------------------------------------------------------------------------
// rwat_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwat_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  rwat_pkg::disp_t                 disp_in,
    input  logic [rwat_pkg::SEQ_W-1:0]      ack_seq_in,
    input  logic [rwat_pkg::ACK_MASK_W-1:0] ack_mask_in,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rwat_pkg::DISP_W-1:0]     disposition,
    output logic [rwat_pkg::SEQ_W-1:0]      ack_seq,
    output logic [rwat_pkg::ACK_MASK_W-1:0] ack_mask
);
    import rwat_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    disp_t                 disp_reg;
    logic [SEQ_W-1:0]      ack_seq_reg;
    logic [ACK_MASK_W-1:0] ack_mask_reg;

    // The slot is free when empty or being drained this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            disp_reg     <= disp_in;
            ack_seq_reg  <= ack_seq_in;
            ack_mask_reg <= ack_mask_in;
        end
    end

    assign out_valid   = valid_reg;
    assign disposition = DISP_W'(disp_reg);
    assign ack_seq     = ack_seq_reg;
    assign ack_mask    = ack_mask_reg;

endmodule

@@ bench/rwat_ack_checker.sv @@
// ----------------------------------------------------------------------------
// rwat_ack_checker
// Watches both channels of the receive window tracker. It classifies each
// accepted sequence number against its own window state and compares each
// result beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwat_ack_checker #(
    parameter int WINDOW_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [rwat_pkg::SEQ_W-1:0]      seq_number,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [rwat_pkg::DISP_W-1:0]     disposition,
    input  logic [rwat_pkg::SEQ_W-1:0]      ack_seq,
    input  logic [rwat_pkg::ACK_MASK_W-1:0] ack_mask,
    output int                              outstanding,
    output int                              mismatches
);

    import rwat_pkg::*;

    typedef struct {
        logic [SEQ_W-1:0]      seq;
        disp_t                 disp;
        logic [SEQ_W-1:0]      ack;
        logic [ACK_MASK_W-1:0] mask;
    } ack_beat_t;

    localparam logic [63:0] WINDOW_MASK = {64{1'b1}} >> (64 - WINDOW_BITS);

    // Window state as the block should hold it
    logic [SEQ_W-1:0] rx_newest;
    logic [63:0]      rx_history;

    ack_beat_t pending_acks[$];
    ack_beat_t due;
    ack_beat_t oldest;

    initial
    begin
        rx_newest   = '0;
        rx_history  = '0;
        outstanding = 0;
        mismatches  = 0;
    end

    // Classify one sequence number and advance the window state
    function automatic disp_t classify_seq(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] gap_len;
        logic [63:0]      moved;
        logic [63:0]      slot;
        if (seq == '0)
            return DISP_INVALID;
        if (rx_newest == '0)
        begin
            rx_newest = seq;
            return DISP_NEWEST;
        end
        if (seq == rx_newest)
            return DISP_DUPLICATE;

        // Ahead of the newest: slide the bitmap up by the gap
        gap_len = seq - rx_newest;
        if (gap_len < 32'h8000_0000)
        begin
            if (gap_len > WINDOW_BITS)
                rx_history = '0;
            else
            begin
                moved      = (gap_len == WINDOW_BITS) ? 64'd0 : (rx_history << gap_len);
                rx_history = (moved | (64'd1 << (gap_len - 1))) & WINDOW_MASK;
            end
            rx_newest = seq;
            return DISP_NEWEST;
        end

        // Behind the newest: fill a hole, flag a repeat, or drop as stale
        gap_len = rx_newest - seq;
        if (gap_len > WINDOW_BITS)
            return DISP_STALE;
        slot = 64'd1 << (gap_len - 1);
        if ((rx_history & slot) != 64'd0)
            return DISP_DUPLICATE;
        rx_history = rx_history | slot;
        return DISP_REORDERED;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want, input logic [31:0] seq);
        $display("mismatch %s: got %h want %h (seq %h) at %0t", what, got, want, seq, $realtime);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Record the prediction for each accepted input beat
            if (in_valid && !in_stall)
            begin
                due.seq  = seq_number;
                due.disp = classify_seq(seq_number);
                due.ack  = rx_newest;
                due.mask = rx_history[ACK_MASK_W-1:0];
                pending_acks.push_back(due);
            end

            // Compare each accepted result beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_acks.size() == 0)
                    report_mismatch("unexpected result beat", ack_seq, '0, '0);
                else
                begin
                    oldest = pending_acks.pop_front();
                    if (disposition !== oldest.disp)
                        report_mismatch("disposition", 32'(disposition), 32'(oldest.disp),
                                        oldest.seq);
                    if (ack_seq !== oldest.ack)
                        report_mismatch("ack_seq", ack_seq, oldest.ack, oldest.seq);
                    if (ack_mask !== oldest.mask)
                        report_mismatch("ack_mask", ack_mask, oldest.mask, oldest.seq);
                end
            end

            outstanding <= pending_acks.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives sequence numbers into the receive window tracker: a directed run
// over the window edges, wrap-around and the half-range case, then random
// traffic around the newest sequence with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import rwat_pkg::*;

    localparam int WINDOW       = 32;
    localparam int RANDOM_BEATS = 1950;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [SEQ_W-1:0]      seq_number = '0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [DISP_W-1:0]     disposition;
    logic [SEQ_W-1:0]      ack_seq;
    logic [ACK_MASK_W-1:0] ack_mask;

    int               outstanding;
    int               mismatches;
    int               cycles     = 0;
    int               stall_left = 0;
    int               stall_roll;
    int               beat_idx   = 0;
    logic [SEQ_W-1:0] head_seq   = '0;

    receive_window_ack_tracker_unit #(
        .WINDOW_BITS (WINDOW)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .seq_number  (seq_number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .disposition (disposition),
        .ack_seq     (ack_seq),
        .ack_mask    (ack_mask)
    );

    rwat_ack_checker #(
        .WINDOW_BITS (WINDOW)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .seq_number  (seq_number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .disposition (disposition),
        .ack_seq     (ack_seq),
        .ack_mask    (ack_mask),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #1 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stall the result channel: short and long holds, with calm stretches
    always @(posedge clk)
    begin
        stall_roll = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ((cycles / 600) % 3 == 2 || stall_roll < 65)
            out_stall <= 1'b0;
        else if (stall_roll < 95)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 40);
        end
    end

    // Idle time after a beat; none at all through some stretches
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if ((beat_idx / 150) % 4 == 3 || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly traffic around the newest sequence, some noise and far jumps
    function automatic logic [SEQ_W-1:0] pick_seq();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            return head_seq + $urandom_range(1, 3);
        if (kind < 65)
            return head_seq - $urandom_range(1, WINDOW);
        if (kind < 72)
            return head_seq + $urandom_range(WINDOW - 1, WINDOW + 2);
        if (kind < 77)
            return head_seq + $urandom_range(4, 80);
        if (kind < 81)
            return head_seq;
        if (kind < 86)
            return head_seq - $urandom_range(WINDOW + 1, 5000);
        if (kind < 89)
            return '0;
        if (kind < 94)
            return $urandom();
        if (kind < 97)
            return head_seq + 32'h7FFF_FFFF + $urandom_range(0, 2);
        return head_seq - (WINDOW + $urandom_range(0, 1));
    endfunction

    // Offer one beat, hold it until taken, then idle for a while
    task automatic send_beat(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] ahead;
        int               gap;
        seq_number <= seq;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        ahead = seq - head_seq;
        if (seq != '0 && (head_seq == '0 || $signed(ahead) > 0))
            head_seq = seq;
        beat_idx = beat_idx + 1;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty window, window edges, half range and wrap-around
        send_beat(32'd0);
        send_beat(32'd100);
        send_beat(32'd100);
        send_beat(32'd99);
        send_beat(32'd99);
        send_beat(32'd68);
        send_beat(32'd67);
        send_beat(32'd0);
        send_beat(32'd101);
        send_beat(32'd133);
        send_beat(32'd166);
        send_beat(32'h8000_00A6);
        send_beat(32'hFFFF_FFFF);
        send_beat(32'h8000_00A5);
        send_beat(32'hFFFF_FFF0);
        send_beat(32'hFFFF_FFFF);
        send_beat(32'd5);
        send_beat(32'hFFFF_FFFE);
        send_beat(32'd1);
        send_beat(32'd0);
        send_beat(32'hFFFF_FFE5);
        send_beat(32'hFFFF_FFE4);
        drain_results();

        // Random traffic, with a full drain part way through
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
                drain_results();
            send_beat(pick_seq());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
